// ===== hw/rtl/dhti_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-hash table package
// Shared types, status codes and the command and status bundles that join
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dhti_pkg;

    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned MAX_CHARS = 9;
    localparam int unsigned KEY_W     = CHAR_W * MAX_CHARS;
    localparam int unsigned HEAD_W    = 64;
    localparam int unsigned PHONE_W   = 32;
    localparam int unsigned SLOT_W    = 4;

    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_STEP,
        S_PROBE,
        S_STORE,
        S_FULL,
        S_SRD,
        S_SCMP,
        S_SEND
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic capture;
        logic quot_load;
        logic step_load;
        logic probe_adv;
        logic wr;
        logic scan_rd;
        logic scan_next;
        logic pend_set;
        logic out_stored;
        logic out_full;
        logic out_pend_mid;
        logic out_pend_last;
        logic out_notfound;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_search;
        logic slot_free;
        logic probes_done;
        logic match;
        logic scan_end;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ===== hw/rtl/dhti_if.sv =====
// ----------------------------------------------------------------------------
// Double-hash table channels
// Valid/ready channels for command words and for result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhti_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 cmd;
    logic [dhti_pkg::HEAD_W-1:0]          name_head;
    logic [dhti_pkg::CHAR_W-1:0]          name_tail;
    logic signed [dhti_pkg::PHONE_W-1:0]  phone;

    modport source (output valid, cmd, name_head, name_tail, phone, input ready);
    modport sink   (input valid, cmd, name_head, name_tail, phone, output ready);
endinterface

interface dhti_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           status;
    logic [dhti_pkg::SLOT_W-1:0]          slot;
    logic signed [dhti_pkg::PHONE_W-1:0]  phone_out;
    logic                                 last;

    modport source (output valid, status, slot, phone_out, last, input ready);
    modport sink   (input valid, status, slot, phone_out, last, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhti_ctrl.sv =====
// ----------------------------------------------------------------------------
// Double-hash table controller
// Sequences hashing, probing, storing and the slot scan of a search.
// ----------------------------------------------------------------------------
`default_nettype none

module dhti_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  dhti_pkg::t_sts i_sts,
    output dhti_pkg::t_cmd o_cmd
);

    dhti_pkg::t_state r_state;
    dhti_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhti_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            dhti_pkg::S_IDLE: begin
                if (i_sts.in_valid) begin
                    n_state = i_sts.in_search ? dhti_pkg::S_SRD : dhti_pkg::S_HASH;
                end
            end
            dhti_pkg::S_HASH: begin
                n_state = dhti_pkg::S_STEP;
            end
            dhti_pkg::S_STEP: begin
                n_state = dhti_pkg::S_PROBE;
            end
            dhti_pkg::S_PROBE: begin
                if (i_sts.slot_free) begin
                    n_state = dhti_pkg::S_STORE;
                end else if (i_sts.probes_done) begin
                    n_state = dhti_pkg::S_FULL;
                end
            end
            dhti_pkg::S_STORE, dhti_pkg::S_FULL, dhti_pkg::S_SEND: begin
                if (i_sts.out_free) begin
                    n_state = dhti_pkg::S_IDLE;
                end
            end
            dhti_pkg::S_SRD: begin
                n_state = dhti_pkg::S_SCMP;
            end
            dhti_pkg::S_SCMP: begin
                if (!i_sts.match || !i_sts.pend_valid || i_sts.out_free) begin
                    n_state = i_sts.scan_end ? dhti_pkg::S_SEND : dhti_pkg::S_SRD;
                end
            end
            default: begin
                n_state = dhti_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            dhti_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_sts.in_valid;
            end
            dhti_pkg::S_HASH: begin
                o_cmd.quot_load = 1'b1;
            end
            dhti_pkg::S_STEP: begin
                o_cmd.step_load = 1'b1;
            end
            dhti_pkg::S_PROBE: begin
                o_cmd.probe_adv = !i_sts.slot_free && !i_sts.probes_done;
            end
            dhti_pkg::S_STORE: begin
                o_cmd.wr         = i_sts.out_free;
                o_cmd.out_stored = i_sts.out_free;
            end
            dhti_pkg::S_FULL: begin
                o_cmd.out_full = i_sts.out_free;
            end
            dhti_pkg::S_SRD: begin
                o_cmd.scan_rd = 1'b1;
            end
            dhti_pkg::S_SCMP: begin
                if (!i_sts.match || !i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.scan_next    = !i_sts.scan_end;
                    o_cmd.pend_set     = i_sts.match;
                    o_cmd.out_pend_mid = i_sts.match && i_sts.pend_valid;
                end
            end
            dhti_pkg::S_SEND: begin
                o_cmd.out_pend_last = i_sts.out_free && i_sts.pend_valid;
                o_cmd.out_notfound  = i_sts.out_free && !i_sts.pend_valid;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/dhti_datapath.sv =====
// ----------------------------------------------------------------------------
// Double-hash table datapath
// Key builder, reciprocal-multiply hash unit, probe index, slot memories,
// pending match and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dhti_datapath #(
    parameter int unsigned TABLE_SLOTS    = 10,
    parameter int unsigned STRIDE_MODULUS = 7,
    parameter int unsigned NAME_CHARS     = 9
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    dhti_in_if.sink          i_in,
    dhti_out_if.source       o_out,
    input  dhti_pkg::t_cmd   i_cmd,
    output dhti_pkg::t_sts   o_sts
);

    localparam int unsigned KEY_W  = dhti_pkg::KEY_W;
    localparam int unsigned CHW    = dhti_pkg::CHAR_W;
    localparam int unsigned PW     = dhti_pkg::PHONE_W;
    localparam int unsigned SW     = dhti_pkg::SLOT_W;
    localparam int unsigned IDX_W  = $clog2(TABLE_SLOTS);
    localparam int unsigned RM_W   = $clog2(STRIDE_MODULUS);
    localparam int unsigned SUM_W  = $clog2(NAME_CHARS * 255 + 1);
    localparam int unsigned PROD_W = SUM_W + SUM_W + 2;
    localparam int unsigned SH_T   = SUM_W + $clog2(TABLE_SLOTS);
    localparam int unsigned SH_M   = SUM_W + $clog2(STRIDE_MODULUS);
    localparam int unsigned MUL_T  = ((1 << SH_T) + TABLE_SLOTS - 1) / TABLE_SLOTS;
    localparam int unsigned MUL_M  = ((1 << SH_M) + STRIDE_MODULUS - 1) / STRIDE_MODULUS;
    localparam int unsigned PRB_W  = $clog2(TABLE_SLOTS + 1);

    logic [KEY_W-1:0]       w_raw;
    logic [KEY_W-1:0]       w_key;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_live;
    logic [PROD_W-1:0]      w_prod_t;
    logic [PROD_W-1:0]      w_prod_m;
    logic [SUM_W-1:0]       w_quot_t;
    logic [SUM_W-1:0]       w_quot_m;
    logic [IDX_W-1:0]       w_home;
    logic [RM_W-1:0]        w_remm;
    logic [IDX_W-1:0]       w_step;
    logic [IDX_W-1:0]       w_step_tbl [STRIDE_MODULUS];
    logic [IDX_W:0]         w_adv;
    logic [IDX_W-1:0]       w_idx_adv;
    logic                   w_out_free;

    logic [KEY_W-1:0]       r_key;
    logic [PW-1:0]          r_phone;
    logic [SUM_W-1:0]       r_sum;
    logic [SUM_W-1:0]       r_quot_t;
    logic [SUM_W-1:0]       r_quot_m;
    logic [IDX_W-1:0]       r_idx;
    logic [IDX_W-1:0]       r_step;
    logic [PRB_W-1:0]       r_probe;
    logic [TABLE_SLOTS-1:0] r_valid;

    logic [KEY_W-1:0]       key_mem   [TABLE_SLOTS];
    logic [PW-1:0]          phone_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]       r_rd_key;
    logic [PW-1:0]          r_rd_phone;
    logic                   r_rd_live;

    logic [IDX_W-1:0]       r_pend_idx;
    logic [PW-1:0]          r_pend_phone;
    logic                   r_pend_valid;

    logic                   r_out_valid;
    dhti_pkg::t_status      r_out_status;
    logic [SW-1:0]          r_out_slot;
    logic [PW-1:0]          r_out_phone;
    logic                   r_out_last;

    // A name ends at its first zero character; later characters count as zero.
    always_comb begin
        w_raw  = {i_in.name_tail, i_in.name_head};
        w_key  = '0;
        w_sum  = '0;
        w_live = 1'b1;
        for (int k = 0; k < dhti_pkg::MAX_CHARS; k++) begin
            if (w_raw[k*CHW +: CHW] == '0 || k >= NAME_CHARS) begin
                w_live = 1'b0;
            end
            if (w_live) begin
                w_key[k*CHW +: CHW] = w_raw[k*CHW +: CHW];
                w_sum = w_sum + SUM_W'(w_raw[k*CHW +: CHW]);
            end
        end
    end

    // Stride reduced modulo the slot count, one entry per remainder value.
    for (genvar g = 0; g < STRIDE_MODULUS; g++) begin : g_step_tbl
        assign w_step_tbl[g] = IDX_W'((STRIDE_MODULUS - g) % TABLE_SLOTS);
    end

    always_comb begin
        w_prod_t  = PROD_W'(r_sum) * PROD_W'(MUL_T);
        w_prod_m  = PROD_W'(r_sum) * PROD_W'(MUL_M);
        w_quot_t  = SUM_W'(w_prod_t >> SH_T);
        w_quot_m  = SUM_W'(w_prod_m >> SH_M);
        w_home    = IDX_W'(r_sum - SUM_W'(r_quot_t * SUM_W'(TABLE_SLOTS)));
        w_remm    = RM_W'(r_sum - SUM_W'(r_quot_m * SUM_W'(STRIDE_MODULUS)));
        w_step    = w_step_tbl[w_remm];
        w_adv     = {1'b0, r_idx} + {1'b0, r_step};
        w_idx_adv = (w_adv >= (IDX_W+1)'(TABLE_SLOTS))
                  ? IDX_W'(w_adv - (IDX_W+1)'(TABLE_SLOTS)) : IDX_W'(w_adv);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key   <= w_key;
            r_phone <= i_in.phone;
            r_sum   <= w_sum;
            r_idx   <= '0;
        end else if (i_cmd.quot_load) begin
            r_quot_t <= w_quot_t;
            r_quot_m <= w_quot_m;
        end else if (i_cmd.step_load) begin
            r_idx   <= w_home;
            r_step  <= w_step;
            r_probe <= '0;
        end else if (i_cmd.probe_adv) begin
            r_idx   <= w_idx_adv;
            r_probe <= r_probe + PRB_W'(1);
        end else if (i_cmd.scan_next) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            key_mem[r_idx]   <= r_key;
            phone_mem[r_idx] <= r_phone;
        end
        if (i_cmd.scan_rd) begin
            r_rd_key   <= key_mem[r_idx];
            r_rd_phone <= phone_mem[r_idx];
            r_rd_live  <= r_valid[r_idx];
        end
        if (i_cmd.pend_set) begin
            r_pend_idx   <= r_idx;
            r_pend_phone <= r_rd_phone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_valid[r_idx] <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_pend_valid <= 1'b0;
            end else if (i_cmd.pend_set) begin
                r_pend_valid <= 1'b1;
            end
        end
    end

    assign w_out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_stored || i_cmd.out_full || i_cmd.out_pend_mid
                     || i_cmd.out_pend_last || i_cmd.out_notfound) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_stored) begin
            r_out_status <= dhti_pkg::ST_STORED;
            r_out_slot   <= SW'(r_idx);
            r_out_phone  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_full) begin
            r_out_status <= dhti_pkg::ST_FULL;
            r_out_slot   <= '0;
            r_out_phone  <= '0;
            r_out_last   <= 1'b1;
        end else if (i_cmd.out_pend_mid || i_cmd.out_pend_last) begin
            r_out_status <= dhti_pkg::ST_FOUND;
            r_out_slot   <= SW'(r_pend_idx);
            r_out_phone  <= r_pend_phone;
            r_out_last   <= i_cmd.out_pend_last;
        end else if (i_cmd.out_notfound) begin
            r_out_status <= dhti_pkg::ST_NOT_FOUND;
            r_out_slot   <= '0;
            r_out_phone  <= '0;
            r_out_last   <= 1'b1;
        end
    end

    assign i_in.ready      = i_cmd.in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.slot      = r_out_slot;
    assign o_out.phone_out = r_out_phone;
    assign o_out.last      = r_out_last;

    always_comb begin
        o_sts.in_valid    = i_in.valid;
        o_sts.in_search   = i_in.cmd;
        o_sts.slot_free   = !r_valid[r_idx];
        o_sts.probes_done = (r_probe == PRB_W'(TABLE_SLOTS));
        o_sts.match       = r_rd_live && (r_rd_key == r_key);
        o_sts.scan_end    = (r_idx == IDX_W'(TABLE_SLOTS - 1));
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_free    = w_out_free;
    end

    a_wr_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |=> r_valid[$past(r_idx)])
        else $error("written slot not marked valid");

    a_wr_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> (!r_valid[r_idx] && i_cmd.out_stored))
        else $error("store into an occupied slot");

    a_home_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step_load |=> ({1'b0, r_idx} < (IDX_W+1)'(TABLE_SLOTS)))
        else $error("home slot out of range");

    a_mid_is_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_status == dhti_pkg::ST_FOUND))
        else $error("non-final word that is not a match");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.out_stored || i_cmd.out_full || i_cmd.out_pend_mid
         || i_cmd.out_pend_last || i_cmd.out_notfound) |-> w_out_free)
        else $error("result register overwritten");

endmodule

`default_nettype wire

// ===== hw/rtl/double_hash_table_insert_search_core.sv =====
// ----------------------------------------------------------------------------
// Double-hash table insert and search core
// Name/telephone table with double-hashing insert and full-scan search.
//
//   Channel  Dir  Word                                 Words per command
//   i_in     in   cmd, name_head, name_tail, phone     -
//   o_out    out  status, slot, phone_out, last        1 (insert), 1..N (search)
//
// An insert accepts the word, forms the reciprocal quotients of the character
// sum, then the home slot and stride, checks slots one at a time (1 to
// TABLE_SLOTS + 1 of them) and then stores the entry or reports a full table.
// A search reads each slot from the slot memory and compares it in the next
// cycle.
// Reset clears the valid bits at once; there is no clearing pass.
// A stalled result register holds the scan until its word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module double_hash_table_insert_search_core #(
    parameter int unsigned TABLE_SLOTS    = 10,
    parameter int unsigned STRIDE_MODULUS = 7,
    parameter int unsigned NAME_CHARS     = 9
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    dhti_in_if.sink     i_in,
    dhti_out_if.source  o_out
);

    dhti_pkg::t_cmd w_cmd;
    dhti_pkg::t_sts w_sts;

    dhti_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    dhti_datapath #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .STRIDE_MODULUS (STRIDE_MODULUS),
        .NAME_CHARS     (NAME_CHARS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

endmodule

`default_nettype wire

// ===== bench/dhti_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Double-hash table bench package
// Command codes shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dhti_tb_pkg;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_op;

endpackage

// ===== bench/dhti_directory_checker.sv =====
// ----------------------------------------------------------------------------
// Double-hash table directory checker
// Watches the command and result channels and keeps a mirror of the name
// table. It works out the expected result words for each accepted command and
// compares every accepted result word, field by field, with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhti_directory_checker #(
    parameter int unsigned TABLE_SLOTS    = 10,
    parameter int unsigned STRIDE_MODULUS = 7,
    parameter int unsigned NAME_CHARS     = 9
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dhti_in_if          i_in_mon,
    dhti_out_if         i_out_mon,
    output int unsigned o_fail_count,
    output int unsigned o_pending
);

    import dhti_pkg::*;
    import dhti_tb_pkg::*;

    typedef struct {
        t_status                    status;
        logic [SLOT_W-1:0]          slot;
        logic signed [PHONE_W-1:0]  phone_out;
        logic                       last;
    } t_result;

    logic [KEY_W-1:0]   dir_key   [TABLE_SLOTS];
    logic [PHONE_W-1:0] dir_phone [TABLE_SLOTS];
    logic               dir_valid [TABLE_SLOTS];
    t_result            expected_words [$];
    int unsigned        err_cnt = 0;

    function automatic logic [KEY_W-1:0] trim_name(input logic [HEAD_W-1:0] head,
                                                   input logic [CHAR_W-1:0] tail);
        logic [KEY_W-1:0] raw;
        logic [KEY_W-1:0] key;
        raw = {tail, head};
        key = '0;
        for (int i = 0; i < NAME_CHARS; i++) begin
            if (raw[CHAR_W*i +: CHAR_W] == '0) break;
            key[CHAR_W*i +: CHAR_W] = raw[CHAR_W*i +: CHAR_W];
        end
        return key;
    endfunction

    function automatic void apply_command(input t_op op, input logic [KEY_W-1:0] key,
                                          input logic [PHONE_W-1:0] phone);
        int unsigned sum;
        int unsigned idx;
        int unsigned stride;
        int          last_hit;
        bit          placed;
        t_result     r;
        sum = 0;
        for (int i = 0; i < NAME_CHARS; i++) sum += key[CHAR_W*i +: CHAR_W];
        r.slot      = '0;
        r.phone_out = '0;
        r.last      = 1'b1;
        if (op == CMD_INSERT) begin
            idx    = sum % TABLE_SLOTS;
            stride = STRIDE_MODULUS - (sum % STRIDE_MODULUS);
            placed = !dir_valid[idx];
            for (int p = 0; p < TABLE_SLOTS && !placed; p++) begin
                idx    = (idx + stride) % TABLE_SLOTS;
                placed = !dir_valid[idx];
            end
            if (placed) begin
                dir_key[idx]   = key;
                dir_phone[idx] = phone;
                dir_valid[idx] = 1'b1;
                r.status       = ST_STORED;
                r.slot         = SLOT_W'(idx);
            end else begin
                r.status = ST_FULL;
            end
            expected_words.push_back(r);
        end else begin
            last_hit = -1;
            for (int s = 0; s < TABLE_SLOTS; s++) begin
                if (dir_valid[s] && dir_key[s] == key) last_hit = s;
            end
            if (last_hit < 0) begin
                r.status = ST_NOT_FOUND;
                expected_words.push_back(r);
            end else begin
                for (int s = 0; s <= last_hit; s++) begin
                    if (dir_valid[s] && dir_key[s] == key) begin
                        r.status    = ST_FOUND;
                        r.slot      = SLOT_W'(s);
                        r.phone_out = dir_phone[s];
                        r.last      = (s == last_hit);
                        expected_words.push_back(r);
                    end
                end
            end
        end
    endfunction

    function automatic void check_field(input string field, input logic signed [63:0] want,
                                        input logic signed [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (dir_valid[s]) dir_valid[s] = 1'b0;
            expected_words.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected result word: status %0d, slot %0d, phone_out %0d",
                           i_out_mon.status, i_out_mon.slot, i_out_mon.phone_out);
                    err_cnt++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("status", want.status, i_out_mon.status);
                    check_field("slot", want.slot, i_out_mon.slot);
                    check_field("phone_out", want.phone_out, i_out_mon.phone_out);
                    check_field("last", want.last, i_out_mon.last);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                apply_command(t_op'(i_in_mon.cmd),
                              trim_name(i_in_mon.name_head, i_in_mon.name_tail),
                              i_in_mon.phone);
            end
        end
        o_fail_count <= err_cnt;
        o_pending    <= expected_words.size();
    end

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Double-hash table insert and search testbench
// Drives directed and random insert and search words into the core under
// several sender and receiver idling patterns, including one long receiver
// hold-off, and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import dhti_pkg::*;
    import dhti_tb_pkg::*;

    localparam int unsigned TABLE_SLOTS    = 10;
    localparam int unsigned STRIDE_MODULUS = 7;
    localparam int unsigned NAME_CHARS     = 9;
    localparam int          CLK_PERIOD     = 12;
    localparam int unsigned RESET_CYCLES   = 10;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASES         = 4;
    localparam int unsigned PHASE_ITEMS    = 25;
    localparam int unsigned DRAIN_CYCLES   = 40;
    localparam int unsigned CYCLE_LIMIT    = 200000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dhti_in_if  in_ch ();
    dhti_out_if out_ch ();

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_stall_pct = 0;
    logic        hold_go      = 1'b0;
    logic        hold_done    = 1'b0;
    int unsigned hold_cnt     = 0;
    int unsigned cycle_count  = 0;
    int unsigned fail_count;
    int unsigned pending;

    logic [HEAD_W-1:0] pool_head [$];
    logic [CHAR_W-1:0] pool_tail [$];

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    double_hash_table_insert_search_core #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .STRIDE_MODULUS (STRIDE_MODULUS),
        .NAME_CHARS     (NAME_CHARS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    dhti_directory_checker #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .STRIDE_MODULUS (STRIDE_MODULUS),
        .NAME_CHARS     (NAME_CHARS)
    ) u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        out_ch.ready <= i_rst_n && !(hold_go && !hold_done)
                        && ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic offer_word(input t_op op, input logic [HEAD_W-1:0] head,
                              input logic [CHAR_W-1:0] tail, input logic [PHONE_W-1:0] phone);
        while ($urandom_range(99) < tx_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= op;
        in_ch.name_head <= head;
        in_ch.name_tail <= tail;
        in_ch.phone     <= phone;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == CMD_INSERT) begin
            pool_head.push_back(head);
            pool_tail.push_back(tail);
        end
    endtask

    task automatic make_name(output logic [HEAD_W-1:0] head, output logic [CHAR_W-1:0] tail);
        logic [KEY_W-1:0] chars;
        int unsigned      len;
        chars = '0;
        len   = $urandom_range(0, NAME_CHARS);
        if ($urandom_range(0, 7) == 0) begin
            chars = KEY_W'({$urandom, $urandom, $urandom});
        end else begin
            for (int i = 0; i < len; i++) begin
                chars[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(1, 255));
            end
            if (len < NAME_CHARS - 1 && $urandom_range(0, 3) == 0) begin
                for (int i = len + 1; i < NAME_CHARS; i++) begin
                    chars[CHAR_W*i +: CHAR_W] = CHAR_W'($urandom_range(0, 255));
                end
            end
        end
        {tail, head} = chars;
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[double_hash_table_insert_search_core] ERROR");
        $finish;
    end

    initial begin
        logic [HEAD_W-1:0] head;
        logic [CHAR_W-1:0] tail;
        t_op               op;
        int unsigned       pick;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_INSERT;
        in_ch.name_head <= '0;
        in_ch.name_tail <= '0;
        in_ch.phone     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Even slots are filled first, so a name whose stride is 2 only
        // revisits taken slots and is dropped while odd slots are free.
        offer_word(CMD_SEARCH, 64'h6261, 8'h00, 32'h1234_5678);
        offer_word(CMD_INSERT, 64'h0, 8'h00, 32'h7FFF_FFFF);
        offer_word(CMD_INSERT, 64'd2, 8'h00, 32'h8000_0000);
        offer_word(CMD_INSERT, 64'd4, 8'h00, 32'h0000_0000);
        offer_word(CMD_INSERT, 64'd6, 8'h00, 32'hFFFF_FFFF);
        offer_word(CMD_INSERT, 64'd8, 8'h00, 32'h0000_0001);
        offer_word(CMD_INSERT, 64'd12, 8'h00, 32'h5555_5555);
        offer_word(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'hAAAA_AAAA);
        offer_word(CMD_INSERT, 64'h7C7B_7A79_7800_6261, 8'h7D, 32'h0000_0777);
        offer_word(CMD_INSERT, 64'h6261, 8'h00, 32'h0000_0999);
        offer_word(CMD_SEARCH, 64'h6261, 8'h00, 32'h0);
        offer_word(CMD_SEARCH, 64'h0, 8'h55, 32'h0);
        offer_word(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 32'h0);
        offer_word(CMD_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFE, 32'h0);
        offer_word(CMD_INSERT, 64'd1, 8'h00, 32'h0000_0101);
        offer_word(CMD_INSERT, 64'd3, 8'h00, 32'h0000_0303);
        offer_word(CMD_INSERT, 64'd5, 8'h00, 32'h0000_0505);
        offer_word(CMD_SEARCH, 64'd12, 8'h00, 32'h0);
        offer_word(CMD_SEARCH, 64'd2, 8'h00, 32'h0);
        offer_word(CMD_INSERT, 64'h0, 8'h00, 32'h0000_0000);

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 0;
                    hold_go <= 1'b1;
                end
                1: begin
                    tx_idle_pct = 85;
                    rx_stall_pct <= 0;
                end
                2: begin
                    tx_idle_pct = 0;
                    rx_stall_pct <= 85;
                end
                default: begin
                    tx_idle_pct = 15;
                    rx_stall_pct <= 15;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                op = ($urandom_range(0, 9) < 4) ? CMD_INSERT : CMD_SEARCH;
                if (op == CMD_SEARCH && $urandom_range(0, 9) < 6) begin
                    pick = $urandom_range(0, pool_head.size() - 1);
                    head = pool_head[pick];
                    tail = pool_tail[pick];
                end else begin
                    make_name(head, tail);
                end
                offer_word(op, head, tail, $urandom);
            end
        end
        in_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[double_hash_table_insert_search_core] OK");
        end else begin
            $display("[double_hash_table_insert_search_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dhti_pkg.sv
hw/rtl/dhti_if.sv
hw/rtl/dhti_ctrl.sv
hw/rtl/dhti_datapath.sv
hw/rtl/double_hash_table_insert_search_core.sv
bench/dhti_tb_pkg.sv
bench/dhti_directory_checker.sv
bench/tb.sv
